### hdl/u8u16_pkg.sv
// Shared types, constants and helper functions of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

   localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;

   // Depth of the result queue; two slots must be free to take a byte.
   localparam int QDEPTH = 3;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } unit_type;

   // What one accepted byte produces: zero, one or two code units.
   typedef struct packed {
      logic [1:0] count;
      unit_type   unit0;
      unit_type   unit1;
   } step_type;

   // A byte decoded on its own: ASCII passes, anything else is replaced.
   function automatic logic [15:0] lone_unit(input logic [7:0] b);
      lone_unit = b[7] ? REPLACEMENT_UNIT : {8'h00, b};
   endfunction

endpackage

### hdl/u8u16_step.sv
// Sequence state and per-byte decode logic of the UTF-8 to UTF-16 decoder.
module u8u16_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          byte_in,
   input  logic                end_of_string,
   output u8u16_pkg::step_type step
);

   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   logic [7:0] held_lead_ff, held_lead_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [1:0] held_count_ff, held_count_in;

   always_comb begin
      step           = '0;
      held_lead_in   = held_lead_ff;
      held_second_in = held_second_ff;
      held_count_in  = HELD_NONE;
      unique case (held_count_ff)
         HELD_ONE: begin
            if (held_lead_ff[5]) begin
               if (end_of_string) begin
                  // Truncated three-byte form: replace the lead, then the
                  // pending byte ends the string on its own.
                  step.count           = 2'd2;
                  step.unit0.code_unit = u8u16_pkg::REPLACEMENT_UNIT;
                  step.unit0.last_unit = 1'b0;
                  step.unit1.code_unit = u8u16_pkg::lone_unit(byte_in);
                  step.unit1.last_unit = 1'b1;
               end else begin
                  held_second_in = byte_in;
                  held_count_in  = HELD_TWO;
               end
            end else begin
               step.count           = 2'd1;
               step.unit0.code_unit = {5'b0, held_lead_ff[4:0], byte_in[5:0]};
               step.unit0.last_unit = end_of_string;
            end
         end
         HELD_TWO: begin
            step.count           = 2'd1;
            step.unit0.code_unit = {held_lead_ff[3:0], held_second_ff[5:0], byte_in[5:0]};
            step.unit0.last_unit = end_of_string;
         end
         default: begin
            if (!end_of_string &&
                (byte_in[7:5] == 3'b110 || byte_in[7:4] == 4'b1110)) begin
               held_lead_in  = byte_in;
               held_count_in = HELD_ONE;
            end else begin
               step.count           = 2'd1;
               step.unit0.code_unit = u8u16_pkg::lone_unit(byte_in);
               step.unit0.last_unit = end_of_string;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff   <= 8'h00;
         held_second_ff <= 8'h00;
         held_count_ff  <= HELD_NONE;
      end else if (accept) begin
         held_lead_ff   <= held_lead_in;
         held_second_ff <= held_second_in;
         held_count_ff  <= held_count_in;
      end
   end

endmodule

### hdl/u8u16_outq.sv
// Three-slot result queue that holds decoded code units until they are taken.
module u8u16_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u8u16_pkg::step_type step,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output u8u16_pkg::unit_type out_unit
);

   u8u16_pkg::unit_type slot_ff [u8u16_pkg::QDEPTH];
   u8u16_pkg::unit_type slot_in [u8u16_pkg::QDEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] base;
   logic [1:0] base_next;
   logic [1:0] added;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_unit  = slot_ff[0];
   // A byte may produce two units, so two slots must be free after no pop.
   assign room      = (count_ff <= 2'd1);

   assign base      = count_ff - {1'b0, pop};
   assign base_next = base + 2'd1;
   assign added     = push ? step.count : 2'd0;

   always_comb begin
      for (int i = 0; i < u8u16_pkg::QDEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i + 1] : slot_ff[i];
      end
      slot_in[u8u16_pkg::QDEPTH - 1] = slot_ff[u8u16_pkg::QDEPTH - 1];
      if (added != 2'd0) begin
         slot_in[base] = step.unit0;
      end
      if (added == 2'd2) begin
         slot_in[base_next] = step.unit1;
      end
      count_in = base + added;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

### hdl/utf8_to_utf16_bmp_decoder_core.sv
// Top level of the UTF-8 to UTF-16 (Basic Multilingual Plane) decoder.
// The core takes one UTF-8 byte per beat and returns 16-bit code units.
// It takes a byte only while at most one unit waits in the result queue,
// and a byte's units queue behind those waiting. Lead bytes are held
// and give no unit until their sequence completes. A three-byte lead cut
// short by the end of the string yields two units from one byte, and the
// rsp port drains at most one unit per cycle, so the three-slot result queue, which
// takes a byte only while at most one unit is waiting, sets the rate: one
// byte per cycle whenever the rsp side keeps up, with a short stall after
// such a two-unit byte. Malformed leads and stray bytes give 0xFFFD.
module utf8_to_utf16_bmp_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_last_unit
);

   u8u16_pkg::step_type step;
   u8u16_pkg::unit_type out_unit;
   logic                accept;

   assign accept = req_valid && req_ready;

   u8u16_step u_step (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_in       (req_byte_in),
      .end_of_string (req_end_of_string),
      .step          (step)
   );

   u8u16_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step      (step),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_unit  (out_unit)
   );

   assign rsp_code_unit = out_unit.code_unit;
   assign rsp_last_unit = out_unit.last_unit;

endmodule

### hdl/u8u16_checker.sv
// Port-level assertions for the decoder core, bound to the top level.
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_byte_in,
   input logic        req_end_of_string,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_last_unit
);

   // A stalled result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit) &&
                                  $stable(rsp_last_unit))
      else $error("result beat changed while stalled");

   // A stalled input beat keeps its value until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_byte_in) &&
                                  $stable(req_end_of_string))
      else $error("input beat changed while stalled");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // With nothing waiting on the result side, the input side is always ready.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result queue");

   // No byte in and nothing waiting means nothing appears next cycle.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid |=> !rsp_valid)
      else $error("result appeared without an input byte");

endmodule

bind utf8_to_utf16_bmp_decoder_core u8u16_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_byte_in       (req_byte_in),
   .req_end_of_string (req_end_of_string),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_code_unit     (rsp_code_unit),
   .rsp_last_unit     (rsp_last_unit)
);
